@@ sv/keyed_map_table_defines.svh @@
// assertion helpers for the keyed map table
`ifndef KEYED_MAP_TABLE_DEFINES_SVH
`define KEYED_MAP_TABLE_DEFINES_SVH

// checked on every rising clock edge outside reset
`define KMT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every rising clock edge, reset included
`define KMT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

@@ sv/kmt_pkg.sv @@
package kmt_pkg;

   // sizing
   localparam int unsigned MAP_SLOTS     = 16;
   localparam int unsigned PAIRS_PER_MAP = 64;
   localparam int unsigned VALUE_BITS    = 64;

   // fixed field widths
   localparam int unsigned OP_W   = 3;
   localparam int unsigned ID_W   = 32;
   localparam int unsigned KEY_W  = 32;
   localparam int unsigned RV_W   = 64;
   localparam int unsigned SIZE_W = 7;

   // derived widths
   localparam int unsigned SLOT_W  = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
   localparam int unsigned IDX_W   = (PAIRS_PER_MAP > 1) ? $clog2(PAIRS_PER_MAP) : 1;
   localparam int unsigned COUNT_W = $clog2(PAIRS_PER_MAP + 1);
   localparam int unsigned ENTRIES = MAP_SLOTS * PAIRS_PER_MAP;
   localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 3'd0,
      OP_INSERT = 3'd1,
      OP_LOOKUP = 3'd2,
      OP_SIZE   = 3'd3,
      OP_EXISTS = 3'd4
   } op_type;

endpackage

@@ sv/kmt_if.sv @@
interface kmt_req_if;
   import kmt_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [ID_W-1:0]   map_id;
   logic [KEY_W-1:0]  key;
   logic [RV_W-1:0]   value;

   modport source (output valid, output op, output map_id, output key, output value,
                   input ready);
   modport sink   (input valid, input op, input map_id, input key, input value,
                   output ready);
endinterface

interface kmt_rsp_if;
   import kmt_pkg::*;

   logic              valid;
   logic              ready;
   logic              found;
   logic [RV_W-1:0]   read_value;
   logic [SIZE_W-1:0] map_size;
   logic              status;

   modport source (output valid, output found, output read_value, output map_size,
                   output status, input ready);
   modport sink   (input valid, input found, input read_value, input map_size,
                   input status, output ready);
endinterface

@@ sv/kmt_ram.sv @@
module kmt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/keyed_map_table.sv @@
// keyed map table: a bank of small key/value maps, each held as a list of
// pairs in insertion order.
// req_chan carries one item per operation: op (create, insert, lookup, size,
// exists), map_id, key and value; the map slot is map_id modulo MAP_SLOTS.
// rsp_chan returns exactly one item per request: found, read_value, map_size
// and status (set when an insert of a new key meets a full map).
// both channels use a valid/ready handshake; an item moves on a rising edge
// with valid and ready high.
// one request is worked on at a time. the slot is taken from map_id (the
// slot count is a power of two), then the key memory is scanned one stored
// key a cycle for an insert or a lookup, until a hit or the map's last pair.
// the result sits in an output register: a new request is taken while it
// waits, and if the receiver stalls the sequencer holds at its last step
// until the register drains. ready is low while a request is in work.
// reset (synchronous, active high) marks every map absent with zero pairs;
// the key and value memories are not cleared, only entries below a map's
// pair count are ever read.
`include "keyed_map_table_defines.svh"

module keyed_map_table (
   input  logic      clock,
   input  logic      reset,
   kmt_req_if.sink   req_chan,
   kmt_rsp_if.source rsp_chan
);
   import kmt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_BASE,
      S_SEARCH,
      S_HIT,
      S_VWAIT,
      S_MISS,
      S_DONE
   } state_type;

   // sequencer and working registers
   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_W-1:0]   idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     match_ff, match_in;
   logic                 found_ff, found_in;
   logic [VALUE_BITS-1:0] rv_ff, rv_in;
   logic                 status_ff, status_in;

   // per-map state, cleared by reset
   logic [MAP_SLOTS-1:0] present_ff, present_in;
   logic [COUNT_W-1:0]   count_ff [MAP_SLOTS];
   logic [COUNT_W-1:0]   count_in [MAP_SLOTS];

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [RV_W-1:0]      rsp_rv_ff, rsp_rv_in;
   logic [SIZE_W-1:0]    rsp_size_ff, rsp_size_in;
   logic                 rsp_status_ff, rsp_status_in;

   // memory ports
   logic                  key_we, key_re;
   logic [ADDR_W-1:0]     key_waddr, key_raddr;
   logic [KEY_W-1:0]      key_rdata;
   logic                  val_we, val_re;
   logic [ADDR_W-1:0]     val_waddr, val_raddr;
   logic [VALUE_BITS-1:0] val_rdata;

   logic [COUNT_W-1:0]    idx_prev;
   logic                  key_hit;
   logic                  op_known;
   logic [COUNT_W-1:0]    size_sel;

   kmt_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_ff),
      .re    (key_re),
      .raddr (key_raddr),
      .rdata (key_rdata)
   );

   kmt_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (val_waddr),
      .wdata (val_ff),
      .re    (val_re),
      .raddr (val_raddr),
      .rdata (val_rdata)
   );

   assign idx_prev = idx_ff - COUNT_W'(1);
   assign key_hit  = pend_ff && (key_rdata == key_ff);
   assign op_known = (op_ff <= OP_W'(OP_EXISTS));
   assign size_sel = (op_known && present_ff[slot_ff]) ? count_ff[slot_ff] : '0;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      slot_in       = slot_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      match_in      = match_ff;
      found_in      = found_ff;
      rv_in         = rv_ff;
      status_in     = status_ff;
      present_in    = present_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_rv_in     = rsp_rv_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_status_in = rsp_status_ff;

      key_we    = 1'b0;
      key_re    = 1'b0;
      key_waddr = base_ff + ADDR_W'(cnt_ff[IDX_W-1:0]);
      key_raddr = base_ff + ADDR_W'(idx_ff[IDX_W-1:0]);
      val_we    = 1'b0;
      val_re    = 1'b0;
      val_waddr = base_ff + ADDR_W'(match_ff);
      val_raddr = base_ff + ADDR_W'(match_ff);

      // result taken by the receiver
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_chan.op;
               id_in     = req_chan.map_id;
               key_in    = req_chan.key;
               val_in    = req_chan.value[VALUE_BITS-1:0];
               slot_in   = '0;
               found_in  = 1'b0;
               rv_in     = '0;
               status_in = 1'b0;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            // remainder of map_id by the slot count, a mask for a power of two
            slot_in  = SLOT_W'(id_ff % ID_W'(MAP_SLOTS));
            state_in = S_BASE;
         end
         S_BASE: begin
            base_in = ADDR_W'(slot_ff * PAIRS_PER_MAP);
            idx_in  = '0;
            pend_in = 1'b0;
            cnt_in  = present_ff[slot_ff] ? count_ff[slot_ff] : '0;
            case (op_ff)
               OP_CREATE, OP_INSERT: begin
                  if (!present_ff[slot_ff]) begin
                     count_in[slot_ff] = '0;
                  end
                  present_in[slot_ff] = 1'b1;
                  state_in = (op_ff == OP_W'(OP_INSERT)) ? S_SEARCH : S_DONE;
               end
               OP_LOOKUP: begin
                  state_in = present_ff[slot_ff] ? S_SEARCH : S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SEARCH: begin
            // one key read a cycle, compared the cycle after
            if (key_hit) begin
               match_in = idx_prev[IDX_W-1:0];
               state_in = S_HIT;
            end else if (idx_ff < cnt_ff) begin
               key_re  = 1'b1;
               idx_in  = idx_ff + COUNT_W'(1);
               pend_in = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               state_in = S_MISS;
            end
         end
         S_HIT: begin
            if (op_ff == OP_W'(OP_INSERT)) begin
               val_we   = 1'b1;
               state_in = S_DONE;
            end else begin
               val_re   = 1'b1;
               found_in = 1'b1;
               state_in = S_VWAIT;
            end
         end
         S_VWAIT: begin
            rv_in    = val_rdata;
            state_in = S_DONE;
         end
         S_MISS: begin
            if (op_ff == OP_W'(OP_INSERT)) begin
               if (cnt_ff < COUNT_W'(PAIRS_PER_MAP)) begin
                  // append the new pair
                  key_we            = 1'b1;
                  val_we            = 1'b1;
                  val_waddr         = key_waddr;
                  count_in[slot_ff] = cnt_ff + COUNT_W'(1);
               end else begin
                  status_in = 1'b1;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = (op_ff == OP_W'(OP_EXISTS)) ? present_ff[slot_ff] : found_ff;
               rsp_rv_in     = RV_W'(rv_ff);
               rsp_size_in   = SIZE_W'(size_sel);
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         present_ff   <= '0;
         for (int s = 0; s < MAP_SLOTS; s++) begin
            count_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         present_ff   <= present_in;
         count_ff     <= count_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      slot_ff       <= slot_in;
      base_ff       <= base_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      match_ff      <= match_in;
      found_ff      <= found_in;
      rv_ff         <= rv_in;
      status_ff     <= status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_rv_ff     <= rsp_rv_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.read_value = rsp_rv_ff;
   assign rsp_chan.map_size   = rsp_size_ff;
   assign rsp_chan.status     = rsp_status_ff;

   // a dropped insert only happens on a full map and never reports a hit
   `KMT_ASSERT(a_full_drop,
      (rsp_chan.valid && rsp_chan.status) |->
         (!rsp_chan.found && rsp_chan.map_size == SIZE_W'(PAIRS_PER_MAP)),
      "dropped insert on a map that is not full")
   // a map never reports more pairs than it can hold
   `KMT_ASSERT(a_size_bound,
      rsp_chan.valid |-> (rsp_chan.map_size <= SIZE_W'(PAIRS_PER_MAP)),
      "map size beyond capacity")
   // one request at a time: no accept right after an accept
   `KMT_ASSERT(a_one_at_a_time,
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready,
      "request taken while busy")
   // the key memory is never written during a scan read
   `KMT_ASSERT(a_key_port, key_we |-> !key_re, "key memory read and written together")
   // reset empties the result register
   `KMT_ASSERT_ALWAYS(a_reset_rsp, reset |=> !rsp_chan.valid, "result pending after reset")

endmodule

@@ tb/tb_keyed_map_table.sv @@
`timescale 1ns / 100ps

module tb_keyed_map_table;
   import kmt_pkg::*;

   // run limits: the worst item is a full scan of a map plus stalls and gaps,
   // allowed for over some 700 items, taken several times over
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_WAIT  = 100;
   localparam int unsigned HOLD_CYCLES = 300;

   // opcodes the block does not know: every field of the reply is zero
   localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

   // stored values keep their low VALUE_BITS bits
   localparam logic [RV_W-1:0] VALUE_MASK = {RV_W{1'b1}} >> (RV_W - VALUE_BITS);

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ID_W-1:0]  map_id;
      logic [KEY_W-1:0] key;
      logic [RV_W-1:0]  value;
   } map_request_type;

   typedef struct packed {
      logic              found;
      logic [RV_W-1:0]   read_value;
      logic [SIZE_W-1:0] map_size;
      logic              status;
   } map_reply_type;

   logic clock;
   logic reset;

   kmt_req_if req_bus ();
   kmt_rsp_if rsp_bus ();

   keyed_map_table uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // ---------------------------------------------------------------------
   // predictor state: our own copy of the map bank
   // ---------------------------------------------------------------------
   bit               map_present_m [MAP_SLOTS];
   int unsigned      pair_count_m  [MAP_SLOTS];
   logic [KEY_W-1:0] key_copy      [MAP_SLOTS][PAIRS_PER_MAP];
   logic [RV_W-1:0]  value_copy    [MAP_SLOTS][PAIRS_PER_MAP];

   // replies predicted at request accept, oldest first
   map_reply_type pending_replies [$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;

   // sender pacing: bursts of random length with random gaps in between
   bit          paced = 0;
   int unsigned burst_left = 0;

   // receiver pattern and the long hold-off asked for by the pressure test
   bit          rx_stall_on = 0;
   bit          hold_req = 0;
   int unsigned hold_left = 0;
   bit          rx_phase = 1;
   int unsigned run_left = 0;

   // first pair in insertion order whose key matches, PAIRS_PER_MAP if none
   function automatic int unsigned find_pair(int unsigned slot, logic [KEY_W-1:0] key);
      for (int unsigned i = 0; i < pair_count_m[slot]; i++) begin
         if (key_copy[slot][i] == key) return i;
      end
      return PAIRS_PER_MAP;
   endfunction

   // applies one request to the map bank copy and returns the reply it causes
   function automatic map_reply_type apply_to_maps(map_request_type rq);
      int unsigned   slot;
      int unsigned   idx;
      bit            known;
      map_reply_type r;
      slot  = rq.map_id % MAP_SLOTS;
      known = 1;
      r     = '0;
      case (rq.op)
         OP_CREATE: begin
            if (!map_present_m[slot]) begin
               map_present_m[slot] = 1;
               pair_count_m[slot]  = 0;
            end
         end
         OP_INSERT: begin
            // an insert creates the map first if needed
            if (!map_present_m[slot]) begin
               map_present_m[slot] = 1;
               pair_count_m[slot]  = 0;
            end
            idx = find_pair(slot, rq.key);
            if (idx < PAIRS_PER_MAP) begin
               value_copy[slot][idx] = rq.value & VALUE_MASK;
            end else if (pair_count_m[slot] < PAIRS_PER_MAP) begin
               idx = pair_count_m[slot];
               key_copy[slot][idx]   = rq.key;
               value_copy[slot][idx] = rq.value & VALUE_MASK;
               pair_count_m[slot]    = idx + 1;
            end else begin
               // new key into a full map: dropped and flagged
               r.status = 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (map_present_m[slot]) begin
               idx = find_pair(slot, rq.key);
               if (idx < PAIRS_PER_MAP) begin
                  r.found      = 1'b1;
                  r.read_value = value_copy[slot][idx];
               end
            end
         end
         OP_SIZE: begin
         end
         OP_EXISTS: begin
            r.found = map_present_m[slot];
         end
         default: begin
            known = 0;
         end
      endcase
      if (known && map_present_m[slot]) r.map_size = SIZE_W'(pair_count_m[slot]);
      return r;
   endfunction

   function automatic map_request_type make_req(logic [OP_W-1:0] op,
                                                logic [ID_W-1:0] map_id,
                                                logic [KEY_W-1:0] key,
                                                logic [RV_W-1:0] value);
      map_request_type rq;
      rq.op     = op;
      rq.map_id = map_id;
      rq.key    = key;
      rq.value  = value;
      return rq;
   endfunction

   // a random map id that lands in the given slot
   function automatic logic [ID_W-1:0] id_for_slot(int unsigned slot);
      logic [ID_W-1:0] raw;
      raw = $urandom;
      return raw - (raw % MAP_SLOTS) + slot;
   endfunction

   function automatic logic [RV_W-1:0] random_value();
      return {$urandom, $urandom};
   endfunction

   // ---------------------------------------------------------------------
   // clock, reset and watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("keyed_map_table: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // sender: one item per call, inputs change on the falling edge
   // ---------------------------------------------------------------------
   task automatic send_request(input map_request_type rq);
      int unsigned gap;
      if (paced) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge clock);
            req_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
      end
      @(negedge clock);
      req_bus.op     = rq.op;
      req_bus.map_id = rq.map_id;
      req_bus.key    = rq.key;
      req_bus.value  = rq.value;
      req_bus.valid  = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // accepted at this edge: predict now so the queue stays in order
      pending_replies.push_back(apply_to_maps(rq));
   endtask

   // drop valid after the last item of a test so nothing is taken twice
   task automatic rest_sender();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // receiver: alternating runs of ready and stall, plus the long hold-off
   // ---------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
         end
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (!rx_stall_on) begin
            rsp_bus.ready = 1'b1;
         end else begin
            if (run_left == 0) begin
               rx_phase = !rx_phase;
               run_left = rx_phase ? $urandom_range(1, 10) : $urandom_range(1, 5);
            end
            rsp_bus.ready = rx_phase;
            run_left--;
         end
      end
   end

   // ---------------------------------------------------------------------
   // reply checker: every accepted reply against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : reply_check
      map_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            $error("reply with no request outstanding");
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_bus.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_bus.found);
               mismatches++;
            end
            if (rsp_bus.read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_bus.read_value);
               mismatches++;
            end
            if (rsp_bus.map_size !== want.map_size) begin
               $error("map_size: expected %0d, got %0d", want.map_size, rsp_bus.map_size);
               mismatches++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // absent maps, create, insert and update, lookups, field extremes and
   // the unknown opcodes
   task automatic test_basic_ops();
      send_request(make_req(OP_EXISTS, 32'd3, '0, '0));
      send_request(make_req(OP_SIZE, 32'd3, '0, '1));
      // a lookup on an absent map leaves it absent
      send_request(make_req(OP_LOOKUP, 32'd3, '0, '0));
      send_request(make_req(OP_EXISTS, 32'd3, '1, '0));
      // slot 15 from the largest id, created twice
      send_request(make_req(OP_CREATE, '1, '1, '1));
      send_request(make_req(OP_CREATE, 32'h0000_001F, '0, '0));
      send_request(make_req(OP_EXISTS, '1, '0, '0));
      send_request(make_req(OP_LOOKUP, '1, '0, '0));
      // insert creates slot 0, then extreme keys and values
      send_request(make_req(OP_INSERT, '0, '0, '0));
      send_request(make_req(OP_INSERT, '0, '1, '1));
      send_request(make_req(OP_LOOKUP, '0, '0, '1));
      send_request(make_req(OP_LOOKUP, '0, '1, '0));
      send_request(make_req(OP_LOOKUP, '0, 32'd1, '0));
      // update in place, seen through another id of the same slot
      send_request(make_req(OP_INSERT, 32'h0000_0010, '0, 64'hA5A5_5A5A_F00F_0FF0));
      send_request(make_req(OP_LOOKUP, 32'hFFFF_FFF0, '0, '0));
      send_request(make_req(OP_SIZE, 32'h8000_0000, '0, '0));
      send_request(make_req(OP_INSERT, '1, 32'h8000_0001, '1));
      send_request(make_req(OP_LOOKUP, '1, 32'h8000_0001, '0));
      send_request(make_req(OP_SIZE, '1, '1, '1));
      // unknown opcodes on a present map: no state change, all zero
      for (int unsigned o = OP_FIRST_UNUSED; o <= OP_LAST_UNUSED; o++) begin
         send_request(make_req(OP_W'(o), '0, '1, '1));
      end
      send_request(make_req(OP_SIZE, '0, '0, '0));
      rest_sender();
   endtask

   // fill one map to capacity, then a dropped insert and an update on it
   task automatic test_full_map();
      int unsigned      slot;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] dropped_key;
      slot  = 7;
      paced = 1;
      while (pair_count_m[slot] < PAIRS_PER_MAP) begin
         key = $urandom;
         while (find_pair(slot, key) < PAIRS_PER_MAP) key = $urandom;
         send_request(make_req(OP_INSERT, id_for_slot(slot), key, random_value()));
      end
      dropped_key = $urandom;
      while (find_pair(slot, dropped_key) < PAIRS_PER_MAP) dropped_key = $urandom;
      send_request(make_req(OP_INSERT, id_for_slot(slot), dropped_key, random_value()));
      send_request(make_req(OP_LOOKUP, id_for_slot(slot), dropped_key, '0));
      // an existing key in a full map still updates
      key = key_copy[slot][PAIRS_PER_MAP - 1];
      send_request(make_req(OP_INSERT, id_for_slot(slot), key, random_value()));
      send_request(make_req(OP_LOOKUP, id_for_slot(slot), key, '0));
      send_request(make_req(OP_LOOKUP, id_for_slot(slot), key_copy[slot][0], '0));
      send_request(make_req(OP_CREATE, id_for_slot(slot), '0, '0));
      send_request(make_req(OP_EXISTS, id_for_slot(slot), '0, '0));
      send_request(make_req(OP_SIZE, id_for_slot(slot), '0, '0));
      paced = 0;
      rest_sender();
   endtask

   // random mix, keys mostly drawn from those already in the chosen map
   task automatic test_random_mix(input int unsigned count, input bit idle_on);
      int unsigned      slot;
      int unsigned      pick;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      paced       = idle_on;
      rx_stall_on = idle_on;
      repeat (count) begin
         slot = $urandom_range(0, MAP_SLOTS - 1);
         pick = $urandom_range(0, 99);
         if (pick < 38)      op = OP_INSERT;
         else if (pick < 68) op = OP_LOOKUP;
         else if (pick < 76) op = OP_SIZE;
         else if (pick < 84) op = OP_EXISTS;
         else if (pick < 92) op = OP_CREATE;
         else                op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
         if (pair_count_m[slot] > 0 && $urandom_range(0, 3) != 0)
            key = key_copy[slot][$urandom_range(0, pair_count_m[slot] - 1)];
         else
            key = $urandom;
         send_request(make_req(op, id_for_slot(slot), key, random_value()));
      end
      paced       = 0;
      rx_stall_on = 0;
      rest_sender();
   endtask

   // receiver holds off for a long stretch while items keep coming, so the
   // output register fills and the block stops taking requests
   task automatic test_output_backpressure();
      int unsigned slot;
      hold_req = 1;
      repeat (12) begin
         slot = $urandom_range(0, MAP_SLOTS - 1);
         send_request(make_req(OP_W'($urandom_range(OP_CREATE, OP_EXISTS)),
                               id_for_slot(slot), $urandom, random_value()));
      end
      rest_sender();
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      req_bus.valid  = 1'b0;
      req_bus.op     = '0;
      req_bus.map_id = '0;
      req_bus.key    = '0;
      req_bus.value  = '0;
      for (int s = 0; s < MAP_SLOTS; s++) begin
         map_present_m[s] = 0;
         pair_count_m[s]  = 0;
      end
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_full_map();
      test_random_mix(150, 1);
      test_output_backpressure();
      // a stretch with no idling on either side
      test_random_mix(130, 0);
      test_random_mix(150, 1);
      test_output_backpressure();
      test_random_mix(100, 1);

      // wait for every outstanding reply, then a little longer for strays
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0)
         $display("keyed_map_table: match");
      else
         $display("keyed_map_table: mismatch");
      $finish;
   end

endmodule
